// ===== src/kwim_pkg.sv =====
// ----------------------------------------------------------------------------
// kwim_pkg: shared types and constants for the k-way interval merge cost block
// field widths, cost saturation limit, sequencer states and a saturating adder
// ----------------------------------------------------------------------------
`default_nettype none

package kwim_pkg;

   localparam int PILE_W = 8;
   localparam int CFG_W  = 6;
   localparam int COST_W = 18;

   localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};
   localparam logic [CFG_W-1:0]  WIDTH_MIN = CFG_W'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_READ,
      ST_ACC,
      ST_WRITE,
      ST_DONE
   } state_type;

   // add two costs, clamp at the saturation limit
   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/k_way_interval_merge_cost_top.sv =====
// ----------------------------------------------------------------------------
// k_way_interval_merge_cost_top: minimum cost to merge a row of piles k at a time
// loads pile weights into a prefix-sum memory, then runs the interval program
// over a span cost memory with one shared add/compare unit
// ----------------------------------------------------------------------------
//
//  channel   ports                                   transfer when
//  -------   -------------------------------------   -----------------------
//  request   start, busy, req_pile_stones,           start high, busy low
//            req_last_pile
//  response  rsp_valid, rsp_possible, rsp_min_cost   rsp_valid high (1 cycle)
//  config    csr_we, csr_wdata                       csr_we high
//
//  a pile that is not the last one is taken while the block stays idle, so busy stays low
//  a last pile with a row of one pile gives the response in the cycle after its transfer
//  otherwise each span does a prefix read, then a memory read and an add/compare
//  per split point, then a write of its cost; the response follows the last span
//  wider merge widths visit fewer split points in each span
//  synchronous active-high reset clears the sequencer and pile count and sets the width to 2
//  the response cannot be held off: it is shown for exactly one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_interval_merge_cost_top
   import kwim_pkg::*;
#(
   parameter int MAX_PILES = 32
) (
   input  wire                clock,
   input  wire                reset,
   // request channel
   input  wire                start,
   output logic               busy,
   input  wire  [PILE_W-1:0]  req_pile_stones,
   input  wire                req_last_pile,
   // response channel
   output logic               rsp_valid,
   output logic               rsp_possible,
   output logic [COST_W-1:0]  rsp_min_cost,
   // configuration
   input  wire                csr_we,
   input  wire  [CFG_W-1:0]   csr_wdata
);

   // pile index, pile count and prefix sum widths
   localparam int IDX_W  = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
   localparam int CNT_W  = $clog2(MAX_PILES + 1);
   localparam int PSUM_W = $clog2(MAX_PILES * 255 + 1);
   // split index plus step, wide enough not to wrap
   localparam int MS_W   = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;
   localparam int MEM_D  = 1 << (2 * IDX_W);

   // memories: prefix_mem[p] holds the sum of piles 0..p, cost_mem[{i,j}] span cost
   logic [PSUM_W-1:0] prefix_mem [0:MAX_PILES-1];
   logic [COST_W-1:0] cost_mem   [0:MEM_D-1];

   // sequencer and loop registers
   state_type          state_ff,    state_in;
   logic [CNT_W-1:0]   cnt_ff,      cnt_in;
   logic [PSUM_W-1:0]  acc_ff,      acc_in;
   logic [CFG_W-1:0]   width_ff;
   logic [CFG_W-1:0]   step_ff,     step_in;
   logic [CFG_W-1:0]   r_ff,        r_in;      // (span length - 1) mod step
   logic [IDX_W-1:0]   last_j_ff,   last_j_in;
   logic [IDX_W-1:0]   i_ff,        i_in;
   logic [IDX_W-1:0]   j_ff,        j_in;
   logic [IDX_W-1:0]   m_ff,        m_in;
   logic [COST_W-1:0]  best_ff,     best_in;
   logic [PSUM_W-1:0]  span_ff,     span_in;
   logic               possible_ff, possible_in;
   logic [COST_W-1:0]  cost_out_ff, cost_out_in;

   // memory read data and diagonal flags, loaded in clocked blocks below
   logic [PSUM_W-1:0]  pre_hi_ff;
   logic [PSUM_W-1:0]  pre_lo_ff;
   logic               lo_zero_ff;
   logic [COST_W-1:0]  rd_a_ff;
   logic [COST_W-1:0]  rd_b_ff;
   logic               a_zero_ff;
   logic               b_zero_ff;

   // combinational helpers
   logic               accept;
   logic               pre_we;
   logic [CNT_W-1:0]   n_cur;
   logic [MS_W-1:0]    m_sum;
   logic [COST_W-1:0]  split_cost;
   logic [COST_W-1:0]  cost_fin;
   logic [CFG_W-1:0]   width_eff;
   logic [IDX_W-1:0]   m_next;

   assign accept = start && (state_ff == ST_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         width_ff <= WIDTH_MIN;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_we) begin
            width_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      step_ff     <= step_in;
      r_ff        <= r_in;
      last_j_ff   <= last_j_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      m_ff        <= m_in;
      best_ff     <= best_in;
      span_ff     <= span_in;
      possible_ff <= possible_in;
      cost_out_ff <= cost_out_in;
   end

   // prefix sum memory: one write per loaded pile, two reads per span
   always_ff @(posedge clock) begin
      if (pre_we) begin
         prefix_mem[cnt_ff[IDX_W-1:0]] <= acc_in;
      end
      if (state_ff == ST_SPAN) begin
         pre_hi_ff  <= prefix_mem[j_ff];
         pre_lo_ff  <= prefix_mem[i_ff - 1'b1];
         lo_zero_ff <= (i_ff == '0);
      end
   end

   // span cost memory: two reads per split point, one write per span
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         cost_mem[{i_ff, j_ff}] <= cost_fin;
      end
      if (state_ff == ST_READ) begin
         rd_a_ff   <= cost_mem[{i_ff, m_ff}];
         rd_b_ff   <= cost_mem[{m_next, j_ff}];
         a_zero_ff <= (m_ff == i_ff);
         b_zero_ff <= (m_next == j_ff);
      end
   end

   // sequencer and shared add/compare unit
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      step_in     = step_ff;
      r_in        = r_ff;
      last_j_in   = last_j_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      m_in        = m_ff;
      best_in     = best_ff;
      span_in     = span_ff;
      possible_in = possible_ff;
      cost_out_in = cost_out_ff;
      pre_we      = 1'b0;

      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);

      n_cur      = (cnt_ff < CNT_W'(MAX_PILES)) ? cnt_ff + 1'b1 : cnt_ff;
      width_eff  = (width_ff < WIDTH_MIN) ? WIDTH_MIN : width_ff;
      m_next     = m_ff + 1'b1;
      m_sum      = MS_W'(m_ff) + MS_W'(step_ff);
      split_cost = sat_add(a_zero_ff ? '0 : rd_a_ff, b_zero_ff ? '0 : rd_b_ff);
      cost_fin   = (r_ff == '0) ? sat_add(best_ff, COST_W'(span_ff)) : best_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // running sum restarts with the first pile of a row
               acc_in = (cnt_ff == '0) ? PSUM_W'(req_pile_stones)
                                       : acc_ff + PSUM_W'(req_pile_stones);
               if (cnt_ff < CNT_W'(MAX_PILES)) begin
                  pre_we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  // piles past the limit are dropped
                  acc_in = acc_ff;
               end
               if (req_last_pile) begin
                  cnt_in    = '0;
                  step_in   = width_eff - 1'b1;
                  last_j_in = IDX_W'(n_cur - 1'b1);
                  i_in      = '0;
                  j_in      = IDX_W'(1);
                  r_in      = (width_eff == WIDTH_MIN) ? '0 : CFG_W'(1);
                  if (n_cur == CNT_W'(1)) begin
                     // single pile row
                     possible_in = 1'b1;
                     cost_out_in = '0;
                     state_in    = ST_DONE;
                  end else begin
                     state_in = ST_SPAN;
                  end
               end
            end
         end
         ST_SPAN: begin
            m_in     = i_ff;
            best_in  = COST_MAX;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (split_cost < best_ff) begin
               best_in = split_cost;
            end
            span_in = pre_hi_ff - (lo_zero_ff ? '0 : pre_lo_ff);
            if (m_sum < MS_W'(j_ff)) begin
               m_in     = IDX_W'(m_sum);
               state_in = ST_READ;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            best_in = cost_fin;
            if (j_ff == last_j_ff) begin
               if (i_ff == '0) begin
                  // whole row done
                  possible_in = (r_ff == '0);
                  cost_out_in = (r_ff == '0) ? cost_fin : '0;
                  state_in    = ST_DONE;
               end else begin
                  // next span length
                  r_in     = (r_ff + 1'b1 == step_ff) ? '0 : r_ff + 1'b1;
                  j_in     = j_ff - i_ff + 1'b1;
                  i_in     = '0;
                  state_in = ST_SPAN;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               j_in     = j_ff + 1'b1;
               state_in = ST_SPAN;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_possible = possible_ff;
   assign rsp_min_cost = cost_out_ff;

endmodule

`default_nettype wire
